### src/aligned_pairs_to_cigar_ops_unit_defines.svh
// Assertion macros used by the checker file of this block.
`ifndef ALIGNED_PAIRS_TO_CIGAR_OPS_UNIT_DEFINES_SVH
`define ALIGNED_PAIRS_TO_CIGAR_OPS_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define APTC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("aptc assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define APTC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("aptc assertion failed");

`endif

### src/aptc_pkg.sv
`timescale 1ns / 1ps

package aptc_pkg;

  // Kinds of cigar operation on the result channel.
  typedef enum logic [1:0] {
    KIND_MATCH  = 2'd0,
    KIND_XINDEL = 2'd1,
    KIND_YINDEL = 2'd2,
    KIND_END    = 2'd3
  } op_kind_e;

  localparam int unsigned LEN_WIDTH = 32;
  localparam logic [LEN_WIDTH-1:0] LEN_MAX = '1;
  localparam int unsigned OPS_MAX = 3;

  // One result word.
  typedef struct packed {
    op_kind_e             kind;
    logic [LEN_WIDTH-1:0] len;
    logic                 last;
  } op_t;

  // Handoff of a group of results from the step logic to the output queue.
  typedef struct packed {
    logic       valid;
    logic [1:0] count;
  } push_t;

  // Saturate a wide length to the result width.
  function automatic logic [LEN_WIDTH-1:0] sat_len(input logic [63:0] v);
    logic [LEN_WIDTH-1:0] r;
    if (|v[63:LEN_WIDTH]) begin
      r = LEN_MAX;
    end else begin
      r = v[LEN_WIDTH-1:0];
    end
    return r;
  endfunction

endpackage

### src/aptc_step.sv
`timescale 1ns / 1ps

module aptc_step #(
  parameter int unsigned COORD_WIDTH = 32
) (
  input  logic                 cmd_i,
  input  logic [COORD_WIDTH-1:0] x_i,
  input  logic [COORD_WIDTH-1:0] y_i,
  input  logic [COORD_WIDTH:0] prev_x_i,
  input  logic [COORD_WIDTH:0] prev_y_i,
  input  logic [31:0]          run_i,
  output aptc_pkg::op_t        ops_o [aptc_pkg::OPS_MAX],
  output logic [1:0]           n_ops_o,
  output logic [COORD_WIDTH:0] prev_x_d_o,
  output logic [COORD_WIDTH:0] prev_y_d_o,
  output logic [31:0]          run_d_o
);
  import aptc_pkg::*;

  localparam int unsigned SW = COORD_WIDTH + 1;

  logic [SW-1:0] x_ext, y_ext;
  logic [SW-1:0] dx, dy, len_x, len_y;
  logic          take, gap_x, gap_y;
  logic [31:0]   run_inc, run_new;

  assign x_ext = {1'b0, x_i};
  assign y_ext = {1'b0, y_i};

  // A pair counts only if it moves forward in both coordinates.
  assign take  = ($signed(x_ext) > $signed(prev_x_i)) && ($signed(y_ext) > $signed(prev_y_i));
  assign dx    = x_ext - prev_x_i;
  assign dy    = y_ext - prev_y_i;
  assign len_x = dx - SW'(1);
  assign len_y = dy - SW'(1);
  assign gap_x = take && (dx > SW'(1));
  assign gap_y = take && (dy > SW'(1));

  // Pending match run after this pair: a gap restarts it at this pair.
  assign run_inc = (run_i == LEN_MAX) ? run_i : run_i + 32'd1;
  always_comb begin
    if (!take) begin
      run_new = run_i;
    end else if (gap_x || gap_y) begin
      run_new = 32'd1;
    end else begin
      run_new = run_inc;
    end
  end

  // Build the ordered list of results for this item.
  always_comb begin
    logic [1:0] n;
    n = 2'd0;
    for (int i = 0; i < OPS_MAX; i++) begin
      ops_o[i] = '{kind: KIND_END, len: '0, last: 1'b0};
    end
    if (gap_x && (run_i != 32'd0)) begin
      ops_o[n] = '{kind: KIND_MATCH, len: run_i, last: 1'b0};
      n = n + 2'd1;
    end
    if (gap_x) begin
      ops_o[n] = '{kind: KIND_XINDEL, len: sat_len(64'(len_x)), last: 1'b0};
      n = n + 2'd1;
    end
    if (gap_y && !gap_x && (run_i != 32'd0)) begin
      ops_o[n] = '{kind: KIND_MATCH, len: run_i, last: 1'b0};
      n = n + 2'd1;
    end
    if (gap_y) begin
      ops_o[n] = '{kind: KIND_YINDEL, len: sat_len(64'(len_y)), last: 1'b0};
      n = n + 2'd1;
    end
    if (cmd_i) begin
      // The trailing run excludes the finish pair itself.
      if (run_new > 32'd1) begin
        ops_o[n] = '{kind: KIND_MATCH, len: run_new - 32'd1, last: 1'b0};
        n = n + 2'd1;
      end
      if (n == 2'd0) begin
        ops_o[0] = '{kind: KIND_END, len: '0, last: 1'b0};
        n = 2'd1;
      end
      ops_o[n - 2'd1].last = 1'b1;
    end
    n_ops_o = n;
  end

  // State update: a finish returns everything to the reset values.
  always_comb begin
    if (cmd_i) begin
      prev_x_d_o = '1;
      prev_y_d_o = '1;
      run_d_o    = '0;
    end else if (take) begin
      prev_x_d_o = x_ext;
      prev_y_d_o = y_ext;
      run_d_o    = run_new;
    end else begin
      prev_x_d_o = prev_x_i;
      prev_y_d_o = prev_y_i;
      run_d_o    = run_i;
    end
  end

endmodule

### src/aptc_outq.sv
`timescale 1ns / 1ps

module aptc_outq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  aptc_pkg::push_t     push_i,
  input  aptc_pkg::op_t       ops_i [aptc_pkg::OPS_MAX],
  output logic                ready_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output aptc_pkg::op_t       head_o
);
  import aptc_pkg::*;

  op_t        q_q [OPS_MAX];
  op_t        q_d [OPS_MAX];
  logic [1:0] count_q, count_d;
  logic [1:0] count_after;
  logic       pop;
  logic       push;

  // Head word leaves when the consumer does not stall.
  assign out_valid_o = (count_q != 2'd0);
  assign head_o      = q_q[0];
  assign pop         = out_valid_o && !out_stall_i;
  assign count_after = count_q - {1'b0, pop};

  // A group is taken only when all of its words fit after this cycle's pop.
  assign ready_o = ((2'd3 - count_after) >= push_i.count);
  assign push    = push_i.valid && ready_o;
  assign count_d = count_after + (push ? push_i.count : 2'd0);

  // Shift out the head and append the new group behind what remains.
  always_comb begin
    logic [1:0] j;
    for (int i = 0; i < OPS_MAX; i++) begin
      j = 2'(i) - count_after;
      if (pop && (i < OPS_MAX - 1)) begin
        q_d[i] = q_q[i + 1];
      end else begin
        q_d[i] = q_q[i];
      end
      if (push && (2'(i) >= count_after) && (j < push_i.count)) begin
        q_d[i] = ops_i[j];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
    end else begin
      count_q <= count_d;
    end
  end

endmodule

### src/aligned_pairs_to_cigar_ops_unit.sv
`timescale 1ns / 1ps

// Turns a stream of aligned (x, y) coordinate pairs into run-length cigar
// words: match runs, x indels and y indels, with a finish word (cmd 1, carrying
// both sequence lengths) closing the alignment and marking its final result
// with last_op, or sending an end marker when it yields nothing else. The
// block takes one input word per cycle unless in_stall_o is raised: each word
// sits in an input register, is decoded in one pass of combinational logic and
// moves as a group of zero to three results into a three-entry output queue,
// which hands out one result per cycle while out_stall_i is low. A word that
// yields no result never waits; a word that yields k results waits only until
// the queue has k free entries, so the sustained rate is one word per cycle
// bounded by one result per cycle on the output. A word's results reach the
// output through the input register and then the output queue.
module aligned_pairs_to_cigar_ops_unit #(
  parameter int unsigned COORD_WIDTH = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 cmd_i,
  input  logic [31:0]          x_coord_i,
  input  logic [31:0]          y_coord_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output aptc_pkg::op_kind_e   op_kind_o,
  output logic [31:0]          run_length_o,
  output logic                 last_op_o
);
  import aptc_pkg::*;

  logic                   in_valid_q;
  logic                   cmd_q;
  logic [COORD_WIDTH-1:0] x_q, y_q;
  logic [COORD_WIDTH:0]   prev_x_q, prev_x_d;
  logic [COORD_WIDTH:0]   prev_y_q, prev_y_d;
  logic [31:0]            run_q, run_d;
  op_t                    ops [OPS_MAX];
  logic [1:0]             n_ops;
  push_t                  push;
  logic                   q_ready;
  logic                   move;
  logic                   in_take;
  op_t                    head;

  // The input register frees up whenever its word moves on.
  assign move       = in_valid_q && q_ready;
  assign in_stall_o = in_valid_q && !q_ready;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (move) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      cmd_q <= cmd_i;
      x_q   <= COORD_WIDTH'(x_coord_i);
      y_q   <= COORD_WIDTH'(y_coord_i);
    end
  end

  // Alignment state advances when a word moves into the output queue.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_x_q <= '1;
      prev_y_q <= '1;
      run_q    <= '0;
    end else if (move) begin
      prev_x_q <= prev_x_d;
      prev_y_q <= prev_y_d;
      run_q    <= run_d;
    end
  end

  aptc_step #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_step (
    .cmd_i      (cmd_q),
    .x_i        (x_q),
    .y_i        (y_q),
    .prev_x_i   (prev_x_q),
    .prev_y_i   (prev_y_q),
    .run_i      (run_q),
    .ops_o      (ops),
    .n_ops_o    (n_ops),
    .prev_x_d_o (prev_x_d),
    .prev_y_d_o (prev_y_d),
    .run_d_o    (run_d)
  );

  assign push.valid = in_valid_q;
  assign push.count = n_ops;

  aptc_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .ops_i       (ops),
    .ready_o     (q_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .head_o      (head)
  );

  assign op_kind_o    = head.kind;
  assign run_length_o = head.len;
  assign last_op_o    = head.last;

endmodule

### src/aptc_checker.sv
`timescale 1ns / 1ps
`include "aligned_pairs_to_cigar_ops_unit_defines.svh"

module aptc_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input aptc_pkg::op_kind_e op_kind_o,
  input logic [31:0]        run_length_o,
  input logic               last_op_o
);
  import aptc_pkg::*;

  // A stalled result word stays offered.
  `APTC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)

  // With the output queue empty, the input side never stalls.
  `APTC_ASSERT_NOW(a_no_stall_when_empty, clk_i, rst_ni, !out_valid_o, !in_stall_o)

  // The end marker has no length and always closes an alignment.
  `APTC_ASSERT_NOW(a_end_marker, clk_i, rst_ni, out_valid_o && (op_kind_o == KIND_END), (run_length_o == 32'd0) && last_op_o)

  // Every real operation covers at least one position.
  `APTC_ASSERT_NOW(a_nonzero_len, clk_i, rst_ni, out_valid_o && (op_kind_o != KIND_END), run_length_o != 32'd0)

endmodule

bind aligned_pairs_to_cigar_ops_unit aptc_checker u_aptc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .op_kind_o    (op_kind_o),
  .run_length_o (run_length_o),
  .last_op_o    (last_op_o)
);

### bench/tb.sv
`timescale 1ns / 1ps

module tb;
  import aptc_pkg::*;

  localparam int unsigned ITEM_TARGET  = 430;
  localparam int unsigned HOLD_CYCLES  = 150;
  localparam int unsigned IDLE_LIMIT   = 2000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned REPORT_MAX   = 10;

  // One directed input word, with up to two results typed in by hand.
  // A row with n_typed of zero is checked against the predictor instead.
  typedef struct packed {
    logic        cmd;
    logic [31:0] x;
    logic [31:0] y;
    logic [1:0]  n_typed;
    op_t         t0;
    op_t         t1;
  } stim_row_t;

  localparam op_t NO_OP    = '{kind: KIND_MATCH, len: '0, last: 1'b0};
  localparam op_t END_LAST = '{kind: KIND_END, len: '0, last: 1'b1};
  localparam op_t XMAX     = '{kind: KIND_XINDEL, len: '1, last: 1'b0};
  localparam op_t YMAX     = '{kind: KIND_YINDEL, len: '1, last: 1'b0};

  localparam int unsigned N_ROWS = 22;
  localparam stim_row_t DIR_ROWS [N_ROWS] = '{
    // A finish straight after reset yields only the end marker.
    '{1'b1, 32'd0, 32'd0, 2'd1, END_LAST, NO_OP},
    // Match run, x gap, y gap, a non-increasing pair, both gaps at once.
    '{1'b0, 32'd0, 32'd0, 2'd0, NO_OP, NO_OP},
    '{1'b0, 32'd1, 32'd1, 2'd0, NO_OP, NO_OP},
    '{1'b0, 32'd5, 32'd2, 2'd0, NO_OP, NO_OP},
    '{1'b0, 32'd6, 32'd7, 2'd0, NO_OP, NO_OP},
    '{1'b0, 32'd6, 32'd8, 2'd0, NO_OP, NO_OP},
    '{1'b0, 32'd10, 32'd12, 2'd0, NO_OP, NO_OP},
    '{1'b1, 32'd20, 32'd20, 2'd0, NO_OP, NO_OP},
    // A skipped finish still flushes the trailing run less one.
    '{1'b0, 32'd0, 32'd0, 2'd0, NO_OP, NO_OP},
    '{1'b0, 32'd1, 32'd1, 2'd0, NO_OP, NO_OP},
    '{1'b0, 32'd2, 32'd2, 2'd0, NO_OP, NO_OP},
    '{1'b1, 32'd2, 32'd2, 2'd0, NO_OP, NO_OP},
    // Largest coordinates give the longest indels, then an empty finish.
    '{1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'd2, XMAX, YMAX},
    '{1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'd1, END_LAST, NO_OP},
    // Indels with no pending run, then a finish that closes a long run.
    '{1'b0, 32'd3, 32'd3, 2'd0, NO_OP, NO_OP},
    '{1'b0, 32'd4, 32'd4, 2'd0, NO_OP, NO_OP},
    '{1'b0, 32'd5, 32'd5, 2'd0, NO_OP, NO_OP},
    '{1'b1, 32'd6, 32'd6, 2'd0, NO_OP, NO_OP},
    // Finish with an x gap only, then a y gap near the top of the range.
    '{1'b1, 32'd7, 32'd0, 2'd0, NO_OP, NO_OP},
    '{1'b0, 32'h8000_0000, 32'd0, 2'd0, NO_OP, NO_OP},
    '{1'b0, 32'h8000_0005, 32'd0, 2'd0, NO_OP, NO_OP},
    '{1'b1, 32'h8000_0001, 32'hFFFF_FFFF, 2'd0, NO_OP, NO_OP}
  };

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        cmd_i       = 1'b0;
  logic [31:0] x_coord_i   = '0;
  logic [31:0] y_coord_i   = '0;
  logic        out_stall_i = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  op_kind_e    op_kind_o;
  logic [31:0] run_length_o;
  logic        last_op_o;

  aligned_pairs_to_cigar_ops_unit u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .cmd_i        (cmd_i),
    .x_coord_i    (x_coord_i),
    .y_coord_i    (y_coord_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .op_kind_o    (op_kind_o),
    .run_length_o (run_length_o),
    .last_op_o    (last_op_o)
  );

  always #10 clk_i = ~clk_i;

  // Predictor state: last accepted coordinates and the pending match run.
  longint      last_x;
  longint      last_y;
  logic [31:0] run_len;
  op_t         step_ops[$];
  op_t         pending_ops[$];

  int unsigned taken_items = 0;
  int unsigned err_count   = 0;
  int          burst_left  = 0;
  bit          hold_req    = 1'b0;

  function automatic logic [31:0] clip_len(input longint d);
    return (d > 64'h0000_0000_FFFF_FFFF) ? '1 : d[31:0];
  endfunction

  function automatic void add_op(input op_kind_e k, input logic [31:0] len);
    step_ops.push_back('{kind: k, len: len, last: 1'b0});
  endfunction

  function automatic void flush_run();
    if (run_len != '0) begin
      add_op(KIND_MATCH, run_len);
      run_len = '0;
    end
  endfunction

  function automatic void clear_alignment();
    last_x  = -1;
    last_y  = -1;
    run_len = '0;
  endfunction

  // Works out the cigar words for one input word into step_ops. Returns 1
  // when the word did something, that is a taken pair or any finish.
  function automatic bit cigar_step(input logic cmd, input logic [31:0] x,
                                    input logic [31:0] y);
    longint sx;
    longint sy;
    bit     taken;
    op_t    tail;
    sx    = {32'b0, x};
    sy    = {32'b0, y};
    taken = cmd;
    step_ops.delete();
    if (sx > last_x && sy > last_y) begin
      if (sx - last_x > 1) begin
        flush_run();
        add_op(KIND_XINDEL, clip_len(sx - last_x - 1));
      end
      if (sy - last_y > 1) begin
        flush_run();
        add_op(KIND_YINDEL, clip_len(sy - last_y - 1));
      end
      if (run_len != LEN_MAX) begin
        run_len++;
      end
      last_x = sx;
      last_y = sy;
      taken  = 1'b1;
    end
    if (cmd) begin
      if (run_len > 1) begin
        add_op(KIND_MATCH, run_len - 1);
      end
      if (step_ops.size() == 0) begin
        add_op(KIND_END, '0);
      end
      tail      = step_ops.pop_back();
      tail.last = 1'b1;
      step_ops.push_back(tail);
      clear_alignment();
    end
    return taken;
  endfunction

  // Offers one word, in bursts with random gaps, and records what it should
  // produce once the block takes it. Called and returning at a falling edge.
  task automatic send_word(input logic cmd, input logic [31:0] x, input logic [31:0] y,
                           input logic [1:0] n_typed, input op_t t0, input op_t t1);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0 && !hold_req) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    cmd_i      <= cmd;
    x_coord_i  <= x;
    y_coord_i  <= y;
    do @(posedge clk_i); while (in_stall_o);
    if (cigar_step(cmd, x, y)) begin
      taken_items++;
    end
    if (n_typed == 2'd0) begin
      foreach (step_ops[i]) pending_ops.push_back(step_ops[i]);
    end else begin
      pending_ops.push_back(t0);
      if (n_typed == 2'd2) begin
        pending_ops.push_back(t1);
      end
    end
    @(negedge clk_i);
  endtask

  // Receiver: a changing stall pattern, and one long hold-off on request.
  int stall_mode = 0;
  int mode_left  = 0;
  int tick       = 0;
  int hold_cnt   = 0;

  always @(negedge clk_i) begin
    tick++;
    if (hold_req) begin
      out_stall_i <= 1'b1;
      hold_cnt++;
      if (hold_cnt == HOLD_CYCLES) begin
        hold_req = 1'b0;
      end
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(20, 80);
      end
      mode_left--;
      case (stall_mode)
        0: begin
          out_stall_i <= 1'b0;
        end
        1: begin
          out_stall_i <= ($urandom_range(0, 3) == 0);
        end
        2: begin
          out_stall_i <= ($urandom_range(0, 3) != 0);
        end
        default: begin
          out_stall_i <= (tick % 3 == 0);
        end
      endcase
    end
  end

  // Compare each accepted result word with the oldest expected one.
  always @(posedge clk_i) begin
    op_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_ops.size() == 0) begin
        err_count++;
        if (err_count <= REPORT_MAX) begin
          $display("unexpected word: kind %0d len %0d last %0b",
                   op_kind_o, run_length_o, last_op_o);
        end
      end else begin
        want = pending_ops.pop_front();
        if (want.kind !== op_kind_o || want.len !== run_length_o ||
            want.last !== last_op_o) begin
          err_count++;
          if (err_count <= REPORT_MAX) begin
            $display("mismatch: expected kind %0d len %0d last %0b, got kind %0d len %0d last %0b",
                     want.kind, want.len, want.last, op_kind_o, run_length_o, last_op_o);
          end
        end
      end
    end
  end

  // Watchdog: end the run if nothing moves on either side for too long.
  int unsigned idle_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles == IDLE_LIMIT) begin
        $display("tb NOT OK");
        $finish;
      end
    end
  end

  initial begin
    logic [31:0] cx;
    logic [31:0] cy;
    logic [31:0] nx;
    logic [31:0] ny;
    int          r;
    bit          held;
    bit          paused;
    held   = 1'b0;
    paused = 1'b0;
    clear_alignment();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed part.
    for (int i = 0; i < N_ROWS; i++) begin
      send_word(DIR_ROWS[i].cmd, DIR_ROWS[i].x, DIR_ROWS[i].y,
                DIR_ROWS[i].n_typed, DIR_ROWS[i].t0, DIR_ROWS[i].t1);
    end

    // Random alignments: mostly well-formed pair streams, some noise.
    while (taken_items < ITEM_TARGET) begin
      if (!held && taken_items >= 120) begin
        hold_req = 1'b1;
        held     = 1'b1;
      end
      if (!paused && taken_items >= 280) begin
        in_valid_i <= 1'b0;
        while (pending_ops.size() != 0) @(posedge clk_i);
        @(negedge clk_i);
        paused = 1'b1;
      end
      if ($urandom_range(0, 19) == 0) begin
        send_word(1'($urandom_range(0, 1)), $urandom, $urandom, 2'd0, NO_OP, NO_OP);
      end
      cx = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 2000);
      cy = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 2000);
      send_word(1'b0, cx, cy, 2'd0, NO_OP, NO_OP);
      repeat ($urandom_range(0, 14)) begin
        r  = $urandom_range(0, 99);
        nx = cx + 1;
        ny = cy + 1;
        if (r < 60) begin
          // Plain match step.
        end else if (r < 72) begin
          nx = cx + $urandom_range(2, 30);
        end else if (r < 84) begin
          ny = cy + $urandom_range(2, 30);
        end else if (r < 90) begin
          nx = cx + $urandom_range(2, 30);
          ny = cy + $urandom_range(2, 30);
        end else if (r < 93) begin
          nx = cx + $urandom;
        end else if (r < 97) begin
          nx = cx - $urandom_range(0, 3);
        end else begin
          nx = $urandom;
          ny = $urandom;
        end
        send_word(1'b0, nx, ny, 2'd0, NO_OP, NO_OP);
        if (r < 93) begin
          cx = nx;
          cy = ny;
        end
      end
      // Close the alignment with its sequence lengths.
      r  = $urandom_range(0, 99);
      nx = cx + 1;
      ny = cy + 1;
      if (r >= 90) begin
        nx = $urandom;
        ny = $urandom;
      end else if (r >= 80) begin
        nx = cx;
        ny = cy;
      end else if (r >= 60) begin
        nx = cx + $urandom_range(1, 40);
        ny = cy + $urandom_range(1, 40);
      end
      send_word(1'b1, nx, ny, 2'd0, NO_OP, NO_OP);
    end

    // Drain and let the block settle before the verdict.
    in_valid_i <= 1'b0;
    while (pending_ops.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_count == 0 && pending_ops.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+src
src/aptc_pkg.sv
src/aptc_step.sv
src/aptc_outq.sv
src/aligned_pairs_to_cigar_ops_unit.sv
src/aptc_checker.sv
bench/tb.sv
